### rtl/sacl_pkg.sv
package sacl_pkg;

  localparam int ADDR_W    = 64;
  localparam int VTAG_W    = 52;
  localparam int DLY_W     = 16;
  localparam int LAT_W     = 17;
  localparam int OUT_WAY_W = 2;
  localparam int CFG_AW    = 5;
  localparam int CFG_DW    = 32;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_WRITE_THROUGH  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_WRITE_ALLOCATE = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_BUS_DELAY      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_HIT_DELAY      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_LOWER_DELAY    = 3'd4;

  localparam logic             ACTION_WRITE = 1'b0;
  localparam logic             ACTION_READ  = 1'b1;

  typedef struct packed {
    logic              action;
    logic [ADDR_W-1:0] address;
  } in_item_t;

  typedef struct packed {
    logic                 hit;
    logic [OUT_WAY_W-1:0] way;
    logic                 allocated;
    logic                 lower_access;
    logic                 writeback_needed;
    logic [VTAG_W-1:0]    victim_tag;
    logic [LAT_W-1:0]     latency;
  } out_item_t;

  typedef struct packed {
    logic             write_through_mode;
    logic             write_allocate_mode;
    logic [DLY_W-1:0] bus_delay;
    logic [DLY_W-1:0] hit_delay;
    logic [DLY_W-1:0] lower_delay;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic clr_en;
    logic rd_en;
    logic look_en;
    logic commit_en;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_free;
  } sts_t;

endpackage

### rtl/sacl_ram.sv
module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/sacl_regs.sv
module sacl_regs
  import sacl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t                 cfg_r;
  cfg_t                 cfg_nxt;
  logic [REG_IDX_W-1:0] idx;
  logic                 wr_en;

  assign idx    = paddr[CFG_AW-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_WRITE_THROUGH:  cfg_nxt.write_through_mode  = pwdata[0];
        REG_WRITE_ALLOCATE: cfg_nxt.write_allocate_mode = pwdata[0];
        REG_BUS_DELAY:      cfg_nxt.bus_delay           = pwdata[DLY_W-1:0];
        REG_HIT_DELAY:      cfg_nxt.hit_delay           = pwdata[DLY_W-1:0];
        REG_LOWER_DELAY:    cfg_nxt.lower_delay         = pwdata[DLY_W-1:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_WRITE_THROUGH:  prdata = CFG_DW'(cfg_r.write_through_mode);
      REG_WRITE_ALLOCATE: prdata = CFG_DW'(cfg_r.write_allocate_mode);
      REG_BUS_DELAY:      prdata = CFG_DW'(cfg_r.bus_delay);
      REG_HIT_DELAY:      prdata = CFG_DW'(cfg_r.hit_delay);
      REG_LOWER_DELAY:    prdata = CFG_DW'(cfg_r.lower_delay);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.write_through_mode  <= 1'b0;
      cfg_r.write_allocate_mode <= 1'b1;
      cfg_r.bus_delay           <= DLY_W'(0);
      cfg_r.hit_delay           <= DLY_W'(1);
      cfg_r.lower_delay         <= DLY_W'(10);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### rtl/sacl_ctrl.sv
module sacl_ctrl
  import sacl_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:  if (sts.clr_last) begin
        state_nxt = ST_IDLE;
      end
      ST_IDLE:   if (in_valid) begin
        state_nxt = ST_LOOK;
      end
      ST_LOOK:   state_nxt = ST_COMMIT;
      ST_COMMIT: if (sts.out_free) begin
        state_nxt = ST_IDLE;
      end
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_CLEAR:  cmd.clr_en = 1'b1;
      ST_IDLE: begin
        in_stall  = 1'b0;
        cmd.rd_en = in_valid;
      end
      ST_LOOK:   cmd.look_en = 1'b1;
      ST_COMMIT: cmd.commit_en = sts.out_free;
      default:   cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### rtl/sacl_dp.sv
module sacl_dp
  import sacl_pkg::*;
#(
  parameter int NUM_SETS    = 64,
  parameter int NUM_WAYS    = 4,
  parameter int BLOCK_BYTES = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      cmd,
  output sts_t      sts,
  input  cfg_t      cfg,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int OB     = $clog2(BLOCK_BYTES + 1) - 1;
  localparam int IB     = $clog2(NUM_SETS + 1) - 1;
  localparam int SETS   = 1 << IB;
  localparam int IDX_W  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int TAG_W  = ADDR_W - OB - IB;
  localparam int WAY_W  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int AGE_W  = WAY_W;
  localparam int META_W = AGE_W + 2;
  localparam logic [IDX_W-1:0] SET_MASK = IDX_W'(SETS - 1);
  localparam logic [AGE_W-1:0] AGE_MAX  = AGE_W'(NUM_WAYS - 1);

  // request
  logic [IDX_W-1:0] set_r;
  logic [TAG_W-1:0] tag_r;
  logic             is_read_r;
  logic [ADDR_W-1:0] addr_sh;
  logic [IDX_W-1:0]  in_set;

  // rows read from the set
  logic [NUM_WAYS-1:0][TAG_W-1:0]  tag_row;
  logic [NUM_WAYS-1:0][META_W-1:0] meta_row;
  logic [NUM_WAYS-1:0]             valid_v;
  logic [NUM_WAYS-1:0]             dirty_v;
  logic [NUM_WAYS-1:0][AGE_W-1:0]  age_v;

  // lookup decision
  logic             hit_c;
  logic [WAY_W-1:0] hw_c;
  logic [WAY_W-1:0] vic_c;
  logic             alloc_c;
  logic             lower_c;
  logic             found_inv;
  logic [AGE_W-1:0] best_age;
  logic             hit_r;
  logic [WAY_W-1:0] hw_r;
  logic [WAY_W-1:0] vic_r;
  logic             alloc_r;
  logic             lower_r;
  logic             mark_dirty_r;
  logic             fill_dirty_r;
  logic [LAT_W-1:0] lat_r;

  // commit
  logic [NUM_WAYS-1:0][TAG_W-1:0]  tag_new;
  logic [NUM_WAYS-1:0][META_W-1:0] meta_new;
  logic [AGE_W:0]                  prev_age;
  logic [WAY_W-1:0]                sel_way;
  logic [31:0]                     way_ext;
  logic [ADDR_W-1:0]               vtag_ext;
  logic                            meta_we;
  logic [IDX_W-1:0]                meta_waddr;
  logic [NUM_WAYS*META_W-1:0]      meta_wdata;

  logic [IDX_W-1:0] clr_cnt_r;
  logic             out_valid_r;
  out_item_t        out_data_r;
  out_item_t        out_nxt;

  assign addr_sh = in_data.address >> OB;
  assign in_set  = addr_sh[IDX_W-1:0] & SET_MASK;

  sacl_ram #(
    .WIDTH (NUM_WAYS * TAG_W),
    .DEPTH (SETS)
  ) u_tag_ram (
    .clk   (clk),
    .we    (cmd.commit_en && alloc_r),
    .waddr (set_r),
    .wdata (tag_new),
    .re    (cmd.rd_en),
    .raddr (in_set),
    .rdata (tag_row)
  );

  sacl_ram #(
    .WIDTH (NUM_WAYS * META_W),
    .DEPTH (SETS)
  ) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .re    (cmd.rd_en),
    .raddr (in_set),
    .rdata (meta_row)
  );

  always_comb begin
    for (int j = 0; j < NUM_WAYS; j++) begin
      valid_v[j] = meta_row[j][META_W-1];
      dirty_v[j] = meta_row[j][META_W-2];
      age_v[j]   = meta_row[j][AGE_W-1:0];
    end
  end

  // hit search, victim choice, and allocate and lower-access decision
  always_comb begin
    hit_c     = 1'b0;
    hw_c      = '0;
    found_inv = 1'b0;
    vic_c     = '0;
    for (int j = NUM_WAYS - 1; j >= 0; j--) begin
      if (valid_v[j] && (tag_row[j] == tag_r)) begin
        hit_c = 1'b1;
        hw_c  = WAY_W'(j);
      end
      if (!valid_v[j]) begin
        found_inv = 1'b1;
        vic_c     = WAY_W'(j);
      end
    end
    best_age = age_v[0];
    if (!found_inv) begin
      for (int j = 1; j < NUM_WAYS; j++) begin
        if (age_v[j] > best_age) begin
          best_age = age_v[j];
          vic_c    = WAY_W'(j);
        end
      end
    end
    if (is_read_r == ACTION_READ) begin
      alloc_c = !hit_c;
      lower_c = !hit_c;
    end else if (cfg.write_through_mode) begin
      alloc_c = !hit_c && cfg.write_allocate_mode;
      lower_c = 1'b1;
    end else begin
      alloc_c = !hit_c;
      lower_c = !hit_c;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      set_r     <= in_set;
      tag_r     <= TAG_W'(in_data.address >> (OB + IB));
      is_read_r <= in_data.action;
    end
    if (cmd.look_en) begin
      hit_r        <= hit_c;
      hw_r         <= hw_c;
      vic_r        <= vic_c;
      alloc_r      <= alloc_c;
      lower_r      <= lower_c;
      mark_dirty_r <= hit_c && (is_read_r == ACTION_WRITE) && !cfg.write_through_mode;
      fill_dirty_r <= (is_read_r == ACTION_WRITE) && !cfg.write_through_mode;
      lat_r        <= LAT_W'(cfg.bus_delay)
                      + LAT_W'(lower_c ? cfg.lower_delay : cfg.hit_delay);
    end
  end

  // age, valid and dirty update of the touched set
  always_comb begin
    sel_way  = hit_r ? hw_r : vic_r;
    prev_age = hit_r ? {1'b0, age_v[hw_r]} : (AGE_W + 1)'(NUM_WAYS);
    tag_new  = tag_row;
    tag_new[vic_r] = tag_r;
    for (int j = 0; j < NUM_WAYS; j++) begin
      meta_new[j] = meta_row[j];
      if (WAY_W'(j) == sel_way) begin
        meta_new[j][AGE_W-1:0] = '0;
      end else if (valid_v[j] && ({1'b0, age_v[j]} < prev_age) && (age_v[j] < AGE_MAX)) begin
        meta_new[j][AGE_W-1:0] = age_v[j] + AGE_W'(1);
      end
      if (alloc_r && (WAY_W'(j) == vic_r)) begin
        meta_new[j][META_W-1] = 1'b1;
        meta_new[j][META_W-2] = fill_dirty_r;
      end else if (mark_dirty_r && (WAY_W'(j) == hw_r)) begin
        meta_new[j][META_W-2] = 1'b1;
      end
    end
  end

  assign meta_we    = cmd.clr_en || (cmd.commit_en && (hit_r || alloc_r));
  assign meta_waddr = cmd.clr_en ? clr_cnt_r : set_r;
  assign meta_wdata = cmd.clr_en ? '0 : meta_new;

  always_comb begin
    way_ext  = 32'((hit_r || alloc_r) ? sel_way : '0);
    vtag_ext = ADDR_W'(tag_row[vic_r]);
    out_nxt.hit              = hit_r;
    out_nxt.way              = way_ext[OUT_WAY_W-1:0];
    out_nxt.allocated        = alloc_r;
    out_nxt.lower_access     = lower_r;
    out_nxt.writeback_needed = alloc_r && valid_v[vic_r] && dirty_v[vic_r];
    out_nxt.victim_tag       = out_nxt.writeback_needed ? vtag_ext[VTAG_W-1:0] : '0;
    out_nxt.latency          = lat_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_en) begin
        clr_cnt_r <= clr_cnt_r + IDX_W'(1);
      end
      if (cmd.commit_en) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit_en) begin
      out_data_r <= out_nxt;
    end
  end

  assign sts.clr_last = (clr_cnt_r == IDX_W'(SETS - 1));
  assign sts.out_free = !out_valid_r || !out_stall;
  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;

endmodule

### rtl/set_assoc_cache_lru_controller_top.sv
// per access: set read, hit and victim decision, then write-back of the set row, before the next is taken
// result is registered at the write-back of the set row, held in an output register while stalled
// the next access is taken while a result still waits; its commit waits for the output register
// the set row is read once per access and written back when a line is hit or filled
// after reset the state memory is cleared, one set per cycle, all 2**floor(log2(NUM_SETS)) sets,
// with in_stall high; configuration writes are taken throughout
module set_assoc_cache_lru_controller_top
  import sacl_pkg::*;
#(
  parameter int NUM_SETS    = 64,
  parameter int NUM_WAYS    = 4,
  parameter int BLOCK_BYTES = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  sacl_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  sacl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  sacl_dp #(
    .NUM_SETS    (NUM_SETS),
    .NUM_WAYS    (NUM_WAYS),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .cfg       (cfg),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
